// ===== rtl/sorted_table_last_match_search_core_assert.svh =====
// Assertion macros for the sorted-table last-match search core.
// Used by the controller and datapath modules; no other dependencies.
`ifndef SORTED_TABLE_LAST_MATCH_SEARCH_CORE_ASSERT_SVH
`define SORTED_TABLE_LAST_MATCH_SEARCH_CORE_ASSERT_SVH

`ifndef SYNTHESIS
// Check a property on the rising edge, skipped while reset is high.
`define STLMS_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("%m: assertion failed");
// Check a property on the rising edge, also during reset.
`define STLMS_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("%m: assertion failed");
`else
`define STLMS_ASSERT(label, clk, rst, prop)
`define STLMS_ASSERT_ALWAYS(label, clk, prop)
`endif

`endif

// ===== rtl/stlms_pkg.sv =====
// Shared types and constants for the sorted-table last-match search core.
// No dependencies; imported by every module of the block.
package stlms_pkg;

  localparam int TABLE_DEPTH_DEFAULT = 1024;
  localparam int INDEX_W             = 10;
  localparam int VALUE_W             = 32;
  localparam int COUNT_W             = 11;

  localparam logic [COUNT_W-1:0] ELEMENT_COUNT_RESET = 11'd1024;

  localparam logic FUNC_LOAD   = 1'b0;
  localparam logic FUNC_SEARCH = 1'b1;

  typedef struct packed {
    logic                      func;
    logic [INDEX_W-1:0]        entry_index;
    logic signed [VALUE_W-1:0] item_value;
  } in_item_t;

  typedef struct packed {
    logic               found;
    logic [INDEX_W-1:0] position;
  } out_item_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_PROBE,
    S_COMPARE,
    S_CHECK
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic write_entry;
    logic start_search;
    logic probe_read;
    logic final_read;
    logic take_compare;
    logic out_load;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic is_search;
    logic lo_lt_hi;
    logic out_busy;
  } dp_status_t;

endpackage

// ===== rtl/stlms_ctrl.sv =====
// Sequencing state machine for the sorted-table last-match search core.
// Depends on stlms_pkg and the assertion macro header.
`include "sorted_table_last_match_search_core_assert.svh"

module stlms_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  stlms_pkg::dp_status_t status,
  output stlms_pkg::dp_cmd_t    cmd
);
  import stlms_pkg::*;

  state_t state;
  state_t state_next;

  // Hold the current state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Choose the next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid && status.is_search) begin
          state_next = S_PROBE;
        end
      end
      S_PROBE: begin
        state_next = status.lo_lt_hi ? S_COMPARE : S_CHECK;
      end
      S_COMPARE: begin
        state_next = S_PROBE;
      end
      S_CHECK: begin
        if (!status.out_busy) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Drive handshake and datapath commands
  always_comb begin
    in_ready = 1'b0;
    cmd      = '0;
    unique case (state)
      S_IDLE: begin
        in_ready         = 1'b1;
        cmd.write_entry  = in_valid && !status.is_search;
        cmd.start_search = in_valid && status.is_search;
      end
      S_PROBE: begin
        cmd.probe_read = status.lo_lt_hi;
        cmd.final_read = !status.lo_lt_hi;
      end
      S_COMPARE: begin
        cmd.take_compare = 1'b1;
      end
      S_CHECK: begin
        cmd.out_load = !status.out_busy;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  `STLMS_ASSERT(a_load_only_when_free, clk, rst, cmd.out_load |-> !status.out_busy)
  `STLMS_ASSERT(a_probe_needs_range, clk, rst, cmd.probe_read |-> status.lo_lt_hi)
  `STLMS_ASSERT(a_compare_returns, clk, rst, state == S_COMPARE |=> state == S_PROBE)

endmodule

// ===== rtl/stlms_datapath.sv =====
// Table memory, search bounds, count register and result register.
// Depends on stlms_pkg and the assertion macro header.
`include "sorted_table_last_match_search_core_assert.svh"

module stlms_datapath #(
  parameter int TABLE_DEPTH = stlms_pkg::TABLE_DEPTH_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  stlms_pkg::in_item_t           in_item,
  input  logic                          cfg_we,
  input  logic [stlms_pkg::COUNT_W-1:0] cfg_wdata,
  output logic                          out_valid,
  input  logic                          out_ready,
  output stlms_pkg::out_item_t          out_item,
  input  stlms_pkg::dp_cmd_t            cmd,
  output stlms_pkg::dp_status_t         status
);
  import stlms_pkg::*;

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = AW + 1;

  logic signed [VALUE_W-1:0] table_mem [TABLE_DEPTH];
  logic signed [VALUE_W-1:0] rd_data;
  logic signed [VALUE_W-1:0] key;
  logic [COUNT_W-1:0]        element_count;
  logic [CW-1:0]             lo;
  logic [CW-1:0]             hi;

  logic [CW-1:0] mid;
  logic [CW-1:0] lo_m1;
  logic [CW-1:0] count_sat;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] wr_addr;
  logic [31:0]   index_ext;
  logic [31:0]   pos_ext;
  logic          index_ok;
  logic          hit;

  // Bounds arithmetic
  always_comb begin
    mid       = lo + ((hi - lo) >> 1);
    lo_m1     = lo - CW'(1);
    count_sat = (32'(element_count) > 32'(TABLE_DEPTH)) ? CW'(TABLE_DEPTH)
                                                         : CW'(element_count);
    rd_addr   = cmd.probe_read ? mid[AW-1:0] : lo_m1[AW-1:0];
    index_ext = 32'(in_item.entry_index);
    index_ok  = index_ext < 32'(TABLE_DEPTH);
    wr_addr   = index_ext[AW-1:0];
    hit       = (lo != '0) && (rd_data == key);
    pos_ext   = 32'(lo_m1);
  end

  assign status.is_search = (in_item.func == FUNC_SEARCH);
  assign status.lo_lt_hi  = lo < hi;
  assign status.out_busy  = out_valid && !out_ready;

  // Write one entry per load beat, read one entry per probe
  always_ff @(posedge clk) begin
    if (cmd.write_entry && index_ok) begin
      table_mem[wr_addr] <= in_item.item_value;
    end
    if (cmd.probe_read || cmd.final_read) begin
      rd_data <= table_mem[rd_addr];
    end
  end

  // Hold the element count register
  always_ff @(posedge clk) begin
    if (rst) begin
      element_count <= ELEMENT_COUNT_RESET;
    end else if (cfg_we) begin
      element_count <= cfg_wdata;
    end
  end

  // Latch the key and narrow the bounds
  always_ff @(posedge clk) begin
    if (rst) begin
      lo <= '0;
      hi <= '0;
    end else if (cmd.start_search) begin
      lo <= '0;
      hi <= count_sat;
    end else if (cmd.take_compare) begin
      if (rd_data <= key) begin
        lo <= mid + CW'(1);
      end else begin
        hi <= mid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start_search) begin
      key <= in_item.item_value;
    end
  end

  // Hold the result beat until it is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_item.found    <= hit;
      out_item.position <= hit ? pos_ext[INDEX_W-1:0] : '0;
    end
  end

  `STLMS_ASSERT(a_bounds_ordered, clk, rst, lo <= hi)
  `STLMS_ASSERT(a_miss_zero_pos, clk, rst,
                out_valid && !out_item.found |-> out_item.position == '0)
  `STLMS_ASSERT(a_load_sets_valid, clk, rst, cmd.out_load |=> out_valid)

endmodule

// ===== rtl/sorted_table_last_match_search_core.sv =====
// Sorted-table last-match search: upper-bound binary search, one probe a
// read-then-compare pair on the table memory. Load beats are written without
// leaving the idle state. A search over n entries runs up to ceil(log2(n+1))
// probes; input reopens in the same cycle its result becomes valid, and a held
// result beat stalls both. Synchronous reset clears control and sets
// element_count to 1024; table undefined.
module sorted_table_last_match_search_core #(
  parameter int TABLE_DEPTH = stlms_pkg::TABLE_DEPTH_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  stlms_pkg::in_item_t           in_item,
  output logic                          out_valid,
  input  logic                          out_ready,
  output stlms_pkg::out_item_t          out_item,
  input  logic                          cfg_we,
  input  logic [stlms_pkg::COUNT_W-1:0] cfg_wdata
);
  import stlms_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  // Sequence the probes
  stlms_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  // Store the table and evaluate the probes
  stlms_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .in_item   (in_item),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cmd       (cmd),
    .status    (status)
  );

endmodule

// ===== bench/sorted_table_last_match_search_core_tb.sv =====
// Self-checking bench for sorted_table_last_match_search_core: loads tables, searches them
// and checks every result against an in-bench last-match predictor.
// Depends on stlms_pkg and the core RTL only.
module sorted_table_last_match_search_core_tb;
  import stlms_pkg::*;

  localparam int          DEPTH         = TABLE_DEPTH_DEFAULT;
  localparam int          SETTLE_CYCLES = 30;
  localparam int          DRAIN_CYCLES  = 40;
  localparam int          RANDOM_BEATS  = 400;
  localparam int          LONG_HOLD     = 300;
  localparam int unsigned CYCLE_LIMIT   = 2_000_000;

  localparam logic signed [VALUE_W-1:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [VALUE_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;

  typedef struct {
    in_item_t beat;
    bit       drain;   // hold this beat back until every result is in
  } pending_beat_t;

  logic                clk       = 1'b0;
  logic                rst       = 1'b1;
  logic                in_valid  = 1'b0;
  logic                in_ready;
  in_item_t            in_item   = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  out_item_t           out_item;
  logic                cfg_we    = 1'b0;
  logic [COUNT_W-1:0]  cfg_wdata = '0;

  // Stimulus side: beats waiting to be offered and the table as the generator sees it
  pending_beat_t       pending_beats[$];
  logic signed [VALUE_W-1:0] stim_tbl[DEPTH];
  int unsigned         random_beats;
  bit                  sender_gaps   = 1'b0;
  bit                  receiver_gaps = 1'b0;

  // Predictor state and expected search results
  logic signed [VALUE_W-1:0] pred_tbl[DEPTH];
  logic [COUNT_W-1:0]  pred_count = ELEMENT_COUNT_RESET;
  out_item_t           expected_lookups[$];

  int unsigned         sender_gap_left;
  int unsigned         receiver_hold_left;
  int unsigned         results_seen;
  int unsigned         mismatches;
  int unsigned         cycle_count;

  sorted_table_last_match_search_core u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Upper-bound binary search for the last entry equal to the key
  function automatic out_item_t last_match_lookup(logic signed [VALUE_W-1:0] key);
    int unsigned n;
    int unsigned lo;
    int unsigned hi;
    int unsigned mid;
    out_item_t   res;
    n  = (pred_count > DEPTH) ? DEPTH : pred_count;
    lo = 0;
    hi = n;
    while (lo < hi) begin
      mid = lo + ((hi - lo) >> 1);
      if (pred_tbl[mid] <= key) lo = mid + 1;
      else hi = mid;
    end
    res = '0;
    if (lo > 0 && pred_tbl[lo - 1] == key) begin
      res.found    = 1'b1;
      res.position = INDEX_W'(lo - 1);
    end
    return res;
  endfunction

  // Mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap();
    if ($urandom_range(0, 15) == 0) return $urandom_range(15, 40);
    return $urandom_range(1, 3);
  endfunction

  function automatic void note_mismatch(string what, int unsigned exp_v, int unsigned act_v);
    if (mismatches < 10)
      $display("mismatch at result %0d: %s expected %0d got %0d",
               results_seen, what, exp_v, act_v);
    mismatches++;
  endfunction

  // Sender: offer queued beats, predict each one as it is accepted
  always @(posedge clk) begin
    if (rst) begin
      in_valid        <= 1'b0;
      sender_gap_left = 0;
    end else begin
      if (cfg_we) pred_count = cfg_wdata;
      if (in_valid && in_ready) begin
        if (in_item.func == FUNC_LOAD) pred_tbl[in_item.entry_index] = in_item.item_value;
        else expected_lookups.push_back(last_match_lookup(in_item.item_value));
      end
      if (!in_valid || in_ready) begin
        if (sender_gap_left > 0) begin
          sender_gap_left--;
          in_valid <= 1'b0;
        end else if (pending_beats.size() != 0 &&
                     !(pending_beats[0].drain && expected_lookups.size() != 0)) begin
          in_item  <= pending_beats[0].beat;
          in_valid <= 1'b1;
          void'(pending_beats.pop_front());
          if (sender_gaps && $urandom_range(0, 3) == 0) sender_gap_left = pick_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: check each result beat, stall at random and twice for a long stretch
  always @(posedge clk) begin
    out_item_t want;
    if (rst) begin
      out_ready          <= 1'b0;
      receiver_hold_left = 0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (expected_lookups.size() == 0) begin
          if (mismatches < 10) $display("result %0d arrived with none expected", results_seen);
          mismatches++;
        end else begin
          want = expected_lookups.pop_front();
          if (out_item.found !== want.found)
            note_mismatch("found", want.found, out_item.found);
          if (out_item.position !== want.position)
            note_mismatch("position", want.position, out_item.position);
        end
        if (results_seen == 40 || results_seen == 200) receiver_hold_left = LONG_HOLD;
      end
      if (receiver_hold_left > 0) begin
        receiver_hold_left--;
        out_ready <= 1'b0;
      end else if (receiver_gaps && $urandom_range(0, 3) == 0) begin
        receiver_hold_left = pick_gap() - 1;
        out_ready          <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Watchdog
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("TEST FAILED");
    $finish;
  end

  task automatic push_beat(logic fn, logic [INDEX_W-1:0] idx,
                           logic signed [VALUE_W-1:0] v, bit drain);
    pending_beat_t b;
    b.beat.func        = fn;
    b.beat.entry_index = idx;
    b.beat.item_value  = v;
    b.drain            = drain;
    pending_beats.push_back(b);
    if (fn == FUNC_LOAD) stim_tbl[idx] = v;
    random_beats++;
  endtask

  task automatic push_load(int unsigned idx, logic signed [VALUE_W-1:0] v);
    push_beat(FUNC_LOAD, INDEX_W'(idx), v, 1'b0);
  endtask

  // Search index field is unused, so randomise it for bit coverage
  task automatic push_search(logic signed [VALUE_W-1:0] v, bit drain);
    push_beat(FUNC_SEARCH, INDEX_W'($urandom_range(0, DEPTH - 1)), v, drain);
  endtask

  // Settle, then look again: a beat popped on the very edge of the check shows up later
  task automatic wait_idle();
    do begin
      while (pending_beats.size() != 0 || in_valid || expected_lookups.size() != 0)
        @(posedge clk);
      repeat (SETTLE_CYCLES) @(posedge clk);
    end while (pending_beats.size() != 0 || in_valid || expected_lookups.size() != 0);
  endtask

  task automatic write_count(int unsigned c);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_wdata <= COUNT_W'(c);
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Write entries [0, n) in ascending order, step size and start picked at random
  task automatic load_sorted(int unsigned n);
    longint      cur;
    longint      step_max;
    int unsigned i;
    case ($urandom_range(0, 3))
      0:       cur = -64'sd2147483648;
      1:       cur = longint'($signed($urandom()));
      2:       cur = longint'($urandom_range(0, 16)) - 8;
      default: cur = 64'sd2147483647 - longint'($urandom_range(0, 50));
    endcase
    case ($urandom_range(0, 3))
      0:       step_max = 2;
      1:       step_max = 1000;
      2:       step_max = 64'd1 << 24;
      default: step_max = 64'd1 << 31;
    endcase
    for (i = 0; i < n; i++) begin
      push_load(i, VALUE_W'(cur));
      cur = cur + longint'($urandom_range(0, int'(step_max)));
      if (cur > 64'sd2147483647) cur = 64'sd2147483647;
    end
  endtask

  // Key drawn from the live prefix, its neighbours, the extremes or anywhere
  function automatic logic signed [VALUE_W-1:0] pick_key(int unsigned n);
    logic signed [VALUE_W-1:0] k;
    int unsigned               r;
    r = $urandom_range(0, 9);
    if (n == 0 && r < 6) r = 6;
    k = stim_tbl[$urandom_range(0, (n == 0) ? 0 : n - 1)];
    case (r)
      5:       k = ($urandom_range(0, 1) != 0) ? k + 1 : k - 1;
      6:       k = $urandom();
      7:       k = VAL_MIN;
      8:       k = VAL_MAX;
      9:       k = $signed($urandom_range(0, 16)) - 8;
      default: ;
    endcase
    return k;
  endfunction

  task automatic search_burst(int unsigned n, int unsigned count);
    int unsigned j;
    for (j = 0; j < count; j++) begin
      // Drop an occasional stray load into the stream
      if (n > 0 && $urandom_range(0, 9) == 0) begin
        if ($urandom_range(0, 1) != 0) push_load($urandom_range(0, n - 1), pick_key(n));
        else push_load($urandom_range(0, DEPTH - 1), $urandom());
      end
      push_search(pick_key(n), $urandom_range(0, 29) == 0);
    end
  endtask

  initial begin
    int unsigned i;
    int unsigned c;
    int unsigned n;
    for (i = 0; i < DEPTH; i++) begin
      stim_tbl[i] = '0;
      pred_tbl[i] = '0;
    end
    random_beats = 0;
    results_seen = 0;
    mismatches   = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Empty table: nothing can match
    write_count(0);
    push_search(VAL_MIN, 1'b0);
    push_search(VAL_MAX, 1'b0);
    push_search(0, 1'b0);

    // Four entries with a run of equal values, plus the top index
    push_load(0, VAL_MIN);
    push_load(1, 0);
    push_load(2, 0);
    push_load(3, VAL_MAX);
    push_load(DEPTH - 1, VAL_MAX);
    write_count(4);
    push_search(VAL_MIN, 1'b0);
    push_search(0, 1'b0);
    push_search(VAL_MAX, 1'b0);
    push_search(-1, 1'b0);
    push_search(1, 1'b0);
    push_search(VAL_MAX - 1, 1'b1);
    push_search(VAL_MIN + 1, 1'b0);

    // Single entry
    write_count(1);
    push_search(VAL_MIN, 1'b0);
    push_search(0, 1'b0);

    // Fill the whole table, then search it at full depth and above it
    load_sorted(DEPTH);
    write_count(DEPTH);
    sender_gaps   = 1'b1;
    receiver_gaps = 1'b1;
    search_burst(DEPTH, 30);
    write_count((1 << COUNT_W) - 1);
    sender_gaps   = 1'b0;
    receiver_gaps = 1'b0;
    search_burst(DEPTH, 30);

    // Random phases, mostly small tables
    random_beats = 0;
    while (random_beats < RANDOM_BEATS) begin
      case ($urandom_range(0, 19))
        0:       c = 0;
        1:       c = DEPTH;
        2:       c = $urandom_range(DEPTH + 1, (1 << COUNT_W) - 1);
        3:       c = $urandom_range(65, DEPTH - 1);
        default: c = $urandom_range(1, 64);
      endcase
      n = (c > DEPTH) ? DEPTH : c;
      write_count(c);
      sender_gaps   = ($urandom_range(0, 3) != 0);
      receiver_gaps = ($urandom_range(0, 3) != 0);
      if (n <= 64) begin
        if ($urandom_range(0, 7) == 0) begin
          // Unsorted prefix from a narrow range so that hits still happen
          for (i = 0; i < n; i++) push_load(i, $signed($urandom_range(0, 8)) - 4);
        end else begin
          load_sorted(n);
        end
      end else begin
        // Copy a neighbour into random entries: order holds, runs grow
        for (i = 0; i < 16; i++) begin
          c = $urandom_range(1, n - 2);
          push_load(c, ($urandom_range(0, 1) != 0) ? stim_tbl[c - 1] : stim_tbl[c + 1]);
        end
      end
      search_burst(n, $urandom_range(10, 40));
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && expected_lookups.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
